[src/wtf8d_pkg.sv]
// ----------------------------------------------------------------------------
// WTF-8 decoder package
// Shared result codes and the record type passed from the front end to the
// output sequencer.
// ----------------------------------------------------------------------------
package wtf8d_pkg;

  typedef enum logic [2:0] {
    ST_CODE_POINT = 3'd0,
    ST_BAD_START  = 3'd1,
    ST_EXP_CONT   = 3'd2,
    ST_OVERLONG   = 3'd3,
    ST_TOO_LARGE  = 3'd4,
    ST_SUMMARY    = 3'd5
  } status_t;

  localparam int CP_W        = 21;
  localparam int OUT_CNT_W   = 16;
  localparam int MAX_RESULTS = 3;
  localparam int QUEUE_DEPTH = 4;

  typedef struct packed {
    logic [CP_W-1:0] code_point;
    status_t         status;
  } slot_t;

  typedef struct packed {
    slot_t [MAX_RESULTS-1:0] slots;
    logic [OUT_CNT_W-1:0]    valid_count;
    logic                    all_valid;
    logic [1:0]              n_results;
  } entry_t;

endpackage

[src/wtf8d_if.sv]
// ----------------------------------------------------------------------------
// WTF-8 decoder channels
// Valid/ready channels for the byte input and the result output.
// ----------------------------------------------------------------------------
interface wtf8d_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_buffer;

  modport source (output valid, output in_byte, output end_of_buffer, input ready);
  modport sink   (input valid, input in_byte, input end_of_buffer, output ready);
endinterface

interface wtf8d_out_if;
  logic        valid;
  logic        ready;
  logic [20:0] code_point;
  logic [2:0]  status;
  logic [15:0] valid_count;
  logic        all_valid;
  logic        last;

  modport source (output valid, output code_point, output status, output valid_count,
                  output all_valid, output last, input ready);
  modport sink   (input valid, input code_point, input status, input valid_count,
                  input all_valid, input last, output ready);
endinterface

[src/wtf8d_front.sv]
// ----------------------------------------------------------------------------
// WTF-8 decoder front end
// Accepts one byte per cycle while the queue is not full, advances the
// sequence state and packs the results the byte causes into one queue record.
// ----------------------------------------------------------------------------
module wtf8d_front #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  wtf8d_in_if.sink          in_ch,
  input  logic              q_full,
  output logic              q_push,
  output wtf8d_pkg::entry_t q_entry
);
  import wtf8d_pkg::*;

  localparam logic [CP_W-1:0] MIN_TWO   = 21'h00080;
  localparam logic [CP_W-1:0] MIN_THREE = 21'h00800;
  localparam logic [CP_W-1:0] MIN_FOUR  = 21'h10000;
  localparam logic [CP_W-1:0] MAX_CP    = 21'h10FFFF;

  logic [CP_W-1:0]        acc_r, acc_nxt;
  logic [1:0]             need_r, need_nxt;
  logic [2:0]             len_r, len_nxt;
  logic [COUNT_WIDTH-1:0] good_r, good_nxt;
  logic                   err_r, err_nxt;

  logic                   accept;
  logic [7:0]             b;
  logic [CP_W-1:0]        acc_sh;
  logic [CP_W-1:0]        lowest;
  logic                   as_lead;
  logic                   good_v;
  logic [3:0]             cand_v;
  slot_t                  cand [4];
  slot_t                  loc [MAX_RESULTS];
  logic [1:0]             n;
  logic [COUNT_WIDTH+OUT_CNT_W-1:0] cnt_wide;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign b           = in_ch.in_byte;

  always_comb begin
    acc_nxt  = acc_r;
    need_nxt = need_r;
    len_nxt  = len_r;
    good_nxt = good_r;
    err_nxt  = err_r;
    as_lead  = 1'b1;
    good_v   = 1'b0;
    cand_v   = '0;
    for (int i = 0; i < 4; i++) begin
      cand[i] = '{code_point: '0, status: ST_CODE_POINT};
    end
    acc_sh   = {acc_r[CP_W-7:0], b[5:0]};
    case (len_r)
      3'd2:    lowest = MIN_TWO;
      3'd3:    lowest = MIN_THREE;
      default: lowest = MIN_FOUR;
    endcase

    if (need_r != 2'd0) begin
      if (b[7:6] == 2'b10) begin
        as_lead  = 1'b0;
        acc_nxt  = acc_sh;
        need_nxt = need_r - 2'd1;
        if (need_r == 2'd1) begin
          acc_nxt   = '0;
          len_nxt   = '0;
          cand_v[1] = 1'b1;
          if (acc_sh < lowest) begin
            cand[1].status = ST_OVERLONG;
          end else if (len_r == 3'd4 && acc_sh > MAX_CP) begin
            cand[1].status = ST_TOO_LARGE;
          end else begin
            good_v             = 1'b1;
            cand[1].code_point = acc_sh;
          end
        end
      end else begin
        cand_v[0]      = 1'b1;
        cand[0].status = ST_EXP_CONT;
        acc_nxt        = '0;
        need_nxt       = '0;
        len_nxt        = '0;
      end
    end

    if (as_lead) begin
      if (b[7] == 1'b0) begin
        cand_v[1]          = 1'b1;
        good_v             = 1'b1;
        cand[1].code_point = {13'd0, b};
      end else if (b[7:5] == 3'b110) begin
        acc_nxt  = {16'd0, b[4:0]};
        need_nxt = 2'd1;
        len_nxt  = 3'd2;
      end else if (b[7:4] == 4'b1110) begin
        acc_nxt  = {17'd0, b[3:0]};
        need_nxt = 2'd2;
        len_nxt  = 3'd3;
      end else if (b[7:3] == 5'b11110) begin
        acc_nxt  = {18'd0, b[2:0]};
        need_nxt = 2'd3;
        len_nxt  = 3'd4;
      end else begin
        cand_v[1]      = 1'b1;
        cand[1].status = ST_BAD_START;
      end
    end

    if (good_v && good_r != '1) begin
      good_nxt = good_r + 1'b1;
    end

    if (in_ch.end_of_buffer && need_nxt != 2'd0) begin
      cand_v[2]      = 1'b1;
      cand[2].status = ST_BAD_START;
    end

    if (cand_v[0] || (cand_v[1] && !good_v) || cand_v[2]) begin
      err_nxt = 1'b1;
    end

    cnt_wide = {{OUT_CNT_W{1'b0}}, good_nxt};
    if (in_ch.end_of_buffer) begin
      cand_v[3]      = 1'b1;
      cand[3].status = ST_SUMMARY;
    end

    for (int i = 0; i < MAX_RESULTS; i++) begin
      loc[i] = '{code_point: '0, status: ST_CODE_POINT};
    end
    n = '0;
    for (int i = 0; i < 4; i++) begin
      if (cand_v[i]) begin
        loc[n] = cand[i];
        n      = n + 2'd1;
      end
    end

    for (int i = 0; i < MAX_RESULTS; i++) begin
      q_entry.slots[i] = loc[i];
    end
    q_entry.valid_count = cnt_wide[OUT_CNT_W-1:0];
    q_entry.all_valid   = !err_nxt;
    q_entry.n_results   = n - 2'd1;
    q_push              = accept && (cand_v != 4'd0);

    if (in_ch.end_of_buffer) begin
      acc_nxt  = '0;
      need_nxt = '0;
      len_nxt  = '0;
      good_nxt = '0;
      err_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r  <= '0;
      need_r <= '0;
      len_r  <= '0;
      good_r <= '0;
      err_r  <= 1'b0;
    end else if (accept) begin
      acc_r  <= acc_nxt;
      need_r <= need_nxt;
      len_r  <= len_nxt;
      good_r <= good_nxt;
      err_r  <= err_nxt;
    end
  end

endmodule

[src/wtf8d_queue.sv]
// ----------------------------------------------------------------------------
// WTF-8 decoder record queue
// Short first-in first-out queue between the front end and the sequencer.
// ----------------------------------------------------------------------------
module wtf8d_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  wtf8d_pkg::entry_t push_entry,
  output logic              full,
  output logic              head_valid,
  output wtf8d_pkg::entry_t head,
  input  logic              pop
);
  import wtf8d_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  entry_t           mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_r, rd_r;
  logic [PTR_W:0]   cnt_r;

  assign full       = (cnt_r == (PTR_W+1)'(QUEUE_DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head       = mem[rd_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wr_r <= wr_r + 1'b1;
      end
      if (pop) begin
        rd_r <= rd_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

[src/wtf8d_back.sv]
// ----------------------------------------------------------------------------
// WTF-8 decoder output sequencer
// Unpacks each queue record into single results behind an output register.
// ----------------------------------------------------------------------------
module wtf8d_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              head_valid,
  input  wtf8d_pkg::entry_t head,
  output logic              pop,
  wtf8d_out_if.source       out_ch
);
  import wtf8d_pkg::*;

  logic              ov_r;
  logic [CP_W-1:0]   cp_r;
  status_t           st_r;
  logic [OUT_CNT_W-1:0] cnt_r;
  logic              ok_r;
  logic              last_r;
  logic [1:0]        idx_r;

  logic              load;
  logic              is_last;
  slot_t             cur;

  assign load    = head_valid && (!ov_r || out_ch.ready);
  assign cur     = head.slots[idx_r];
  assign is_last = (idx_r == head.n_results);
  assign pop     = load && is_last;

  assign out_ch.valid       = ov_r;
  assign out_ch.code_point  = cp_r;
  assign out_ch.status      = st_r;
  assign out_ch.valid_count = cnt_r;
  assign out_ch.all_valid   = ok_r;
  assign out_ch.last        = last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r  <= 1'b0;
      idx_r <= '0;
    end else begin
      if (load) begin
        ov_r  <= 1'b1;
        idx_r <= is_last ? 2'd0 : idx_r + 2'd1;
      end else if (out_ch.ready) begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cp_r   <= cur.code_point;
      st_r   <= cur.status;
      cnt_r  <= (cur.status == ST_SUMMARY) ? head.valid_count : '0;
      ok_r   <= (cur.status == ST_SUMMARY) ? head.all_valid : 1'b0;
      last_r <= is_last;
    end
  end

endmodule

[src/wtf8_stream_decoder.sv]
// ----------------------------------------------------------------------------
// WTF-8 stream decoder
// Channel   Direction  Payload
// in_ch     input      in_byte[7:0], end_of_buffer
// out_ch    output     code_point[20:0], status[2:0], valid_count[15:0],
//                      all_valid, last
// A byte is taken every cycle while the four-record queue has room; the
// front end decodes it in that same cycle. Results leave one per cycle from
// the output register while out_ch.ready is high; a byte causing k results
// gives k transfers. Synchronous reset empties the queue and closes any open
// sequence. A stalled output fills the queue, after which in_ch.ready falls.
// ----------------------------------------------------------------------------
module wtf8_stream_decoder #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  wtf8d_in_if.sink    in_ch,
  wtf8d_out_if.source out_ch
);
  import wtf8d_pkg::*;

  logic   q_full;
  logic   q_push;
  entry_t q_entry;
  logic   head_valid;
  entry_t head;
  logic   pop;

  wtf8d_front #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_push (q_push),
    .q_entry(q_entry)
  );

  wtf8d_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_entry(q_entry),
    .full      (q_full),
    .head_valid(head_valid),
    .head      (head),
    .pop       (pop)
  );

  wtf8d_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head_valid(head_valid),
    .head      (head),
    .pop       (pop),
    .out_ch    (out_ch)
  );

endmodule
